// File: rtl/core/sqd_pkg.sv
// Shared constants, types and helpers of the shortest-queue dispatcher.
`default_nettype none
package sqd_pkg;

  localparam int NUM_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 16;

  localparam int SVC_W   = 4;
  localparam int ACT_W   = 4;
  localparam int WAIT_W  = 32;
  localparam int DEP_W   = 4;
  localparam int CHOSE_W = 3;

  localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int IW      = QW + 1;
  localparam int CNT_W   = $clog2(NUM_QUEUES + 1);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int LEN_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_N = NUM_QUEUES * QUEUE_DEPTH;
  localparam int SA_W    = $clog2(STORE_N);

  localparam logic [ACT_W-1:0] ACTIVE_RESET = ACT_W'(8);
  localparam logic [DEP_W-1:0] DEP_MAX      = {DEP_W{1'b1}};

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [SVC_W-1:0] rem;
  } sqd_desc_t;

  localparam int DESC_W = $bits(sqd_desc_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARR_SCAN,
    ST_ARR_WR,
    ST_TICK_EVAL,
    ST_TICK_POP,
    ST_DONE
  } sqd_state_e;

  typedef enum logic {
    FUNC_ARRIVAL = 1'b0,
    FUNC_TICK    = 1'b1
  } sqd_func_e;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [SA_W-1:0] store_addr(input logic [QW-1:0] q,
                                                 input logic [PTR_W-1:0] p);
    return SA_W'(q) * SA_W'(QUEUE_DEPTH) + SA_W'(p);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/sqd_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sqd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                      wdata_i,
  input  wire logic                                  re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/shortest_queue_dispatch_with_service_unit.sv
// Top level of the join-shortest-queue dispatcher with service countdown.
//
//   port group   direction  handshake               contents
//   in           in         in_valid_i/in_ready_o   func_i, service_time_i
//   out          out        out_valid_o/out_ready_i chosen_queue_o, dropped_o, any_busy_o,
//                                                   departures_o, wait_total_o
//   cfg          in         cfg_we_i                cfg_wdata_i (active queue count)
//
// An arrival reads one descriptor RAM entry per active queue for the minimum
// search, writes in ST_ARR_WR and gives its result from ST_DONE. A tick visits
// each active queue, with a pass through ST_TICK_POP for each pop that needs
// the next job's time from the job store RAM. One item is in flight; the output
// register holds a result so the next transaction may enter. Reset clears control
// state and the descriptor valid bits; no clearing pass. A full output stalls in ST_DONE.
`default_nettype none
module shortest_queue_dispatch_with_service_unit
  import sqd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               func_i,
  input  wire logic [SVC_W-1:0]   service_time_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [CHOSE_W-1:0]      chosen_queue_o,
  output logic                    dropped_o,
  output logic                    any_busy_o,
  output logic [DEP_W-1:0]        departures_o,
  output logic [WAIT_W-1:0]       wait_total_o,
  input  wire logic               cfg_we_i,
  input  wire logic [ACT_W-1:0]   cfg_wdata_i
);

  sqd_state_e state_q, state_d;

  logic [ACT_W-1:0]  active_q;
  logic [CNT_W-1:0]  n_cnt;
  logic [QW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     idx_inc;
  logic              more;
  logic              func_q, func_d;
  logic [SVC_W-1:0]  svc_q, svc_d;
  sqd_desc_t         best_q, best_d;
  logic [QW-1:0]     best_idx_q, best_idx_d;
  sqd_desc_t         pend_q, pend_d;
  logic              drop_q, drop_d;
  logic              busy_q, busy_d;
  logic [DEP_W-1:0]  deps_q, deps_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  logic [NUM_QUEUES-1:0] vld_q;

  logic              desc_we, desc_re;
  logic [QW-1:0]     desc_waddr, desc_raddr;
  sqd_desc_t         desc_wdata, desc_rdata, desc;
  logic              store_we, store_re;
  logic [SA_W-1:0]   store_waddr, store_raddr;
  logic [SVC_W-1:0]  store_rdata;

  logic              in_fire, load_out;
  logic              pop, pop_rd;
  logic [PTR_W-1:0]  head_nxt;
  logic [LEN_W-1:0]  len_dec;
  logic [WAIT_W:0]   wait_sum;

  logic              out_valid_q;
  logic [CHOSE_W-1:0] out_chosen_q;
  logic              out_drop_q, out_busy_q;
  logic [DEP_W-1:0]  out_deps_q;
  logic [WAIT_W-1:0] out_wait_q;

  sqd_ram #(.WIDTH(DESC_W), .DEPTH(NUM_QUEUES)) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (desc_we),
    .waddr_i (desc_waddr),
    .wdata_i (desc_wdata),
    .re_i    (desc_re),
    .raddr_i (desc_raddr),
    .rdata_o (desc_rdata)
  );

  sqd_ram #(.WIDTH(SVC_W), .DEPTH(STORE_N)) u_job_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (svc_q),
    .re_i    (store_re),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  always_comb begin
    if (active_q == '0) begin
      n_cnt = CNT_W'(1);
    end else if (32'(active_q) > NUM_QUEUES) begin
      n_cnt = CNT_W'(NUM_QUEUES);
    end else begin
      n_cnt = CNT_W'(active_q);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign load_out   = (state_q == ST_DONE) & (~out_valid_q | out_ready_i);
  assign idx_inc    = {1'b0, idx_q} + IW'(1);
  assign more       = idx_inc < IW'(n_cnt);

  // Descriptors never written read as empty queues
  assign desc     = vld_q[idx_q] ? desc_rdata : '0;
  assign pop      = (desc.len != '0) & (desc.rem <= SVC_W'(1));
  assign len_dec  = desc.len - LEN_W'(1);
  assign head_nxt = ptr_next(desc.head);
  assign pop_rd   = pop & (len_dec != '0);
  assign wait_sum = {1'b0, wait_q} + (WAIT_W + 1)'(len_dec);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (func_i == FUNC_TICK) ? ST_TICK_EVAL : ST_ARR_SCAN;
        end
      end
      ST_ARR_SCAN: begin
        if (!more) begin
          state_d = ST_ARR_WR;
        end
      end
      ST_ARR_WR: state_d = ST_DONE;
      ST_TICK_EVAL: begin
        if (pop_rd) begin
          state_d = ST_TICK_POP;
        end else if (!more) begin
          state_d = ST_DONE;
        end
      end
      ST_TICK_POP: begin
        state_d = more ? ST_TICK_EVAL : ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    idx_d       = idx_q;
    func_d      = func_q;
    svc_d       = svc_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    pend_d      = pend_q;
    drop_d      = drop_q;
    busy_d      = busy_q;
    deps_d      = deps_q;
    wait_d      = wait_q;
    desc_we     = 1'b0;
    desc_waddr  = idx_q;
    desc_wdata  = '0;
    desc_re     = 1'b0;
    desc_raddr  = QW'(idx_inc);
    store_we    = 1'b0;
    store_waddr = store_addr(best_idx_q, best_q.tail);
    store_re    = 1'b0;
    store_raddr = store_addr(idx_q, head_nxt);
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          func_d     = func_i;
          svc_d      = service_time_i;
          idx_d      = '0;
          best_idx_d = '0;
          drop_d     = 1'b0;
          busy_d     = 1'b0;
          deps_d     = '0;
          desc_re    = 1'b1;
          desc_raddr = '0;
        end
      end
      ST_ARR_SCAN: begin
        if ((idx_q == '0) || (desc.len < best_q.len)) begin
          best_d     = desc;
          best_idx_d = idx_q;
        end
        if (more) begin
          desc_re = 1'b1;
          idx_d   = QW'(idx_inc);
        end
      end
      ST_ARR_WR: begin
        if (32'(best_q.len) >= QUEUE_DEPTH) begin
          drop_d = 1'b1;
        end else begin
          store_we        = 1'b1;
          desc_we         = 1'b1;
          desc_waddr      = best_idx_q;
          desc_wdata.len  = best_q.len + LEN_W'(1);
          desc_wdata.head = best_q.head;
          desc_wdata.tail = ptr_next(best_q.tail);
          desc_wdata.rem  = (best_q.len == '0) ? svc_q : best_q.rem;
        end
      end
      ST_TICK_EVAL: begin
        if (desc.len != '0) begin
          busy_d = 1'b1;
          wait_d = wait_sum[WAIT_W] ? {WAIT_W{1'b1}} : wait_sum[WAIT_W-1:0];
          if (pop && deps_q != DEP_MAX) begin
            deps_d = deps_q + DEP_W'(1);
          end
          pend_d.len  = len_dec;
          pend_d.head = head_nxt;
          pend_d.tail = desc.tail;
          pend_d.rem  = '0;
          if (pop_rd) begin
            store_re = 1'b1;
          end else begin
            desc_we = 1'b1;
            if (pop) begin
              desc_wdata = pend_d;
            end else begin
              desc_wdata     = desc;
              desc_wdata.rem = desc.rem - SVC_W'(1);
            end
          end
        end
        if (!pop_rd && more) begin
          desc_re = 1'b1;
          idx_d   = QW'(idx_inc);
        end
      end
      ST_TICK_POP: begin
        desc_we        = 1'b1;
        desc_wdata     = pend_q;
        desc_wdata.rem = store_rdata;
        if (more) begin
          desc_re = 1'b1;
          idx_d   = QW'(idx_inc);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= ACTIVE_RESET;
      wait_q      <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      if (cfg_we_i) begin
        active_q <= cfg_wdata_i;
      end
      if (desc_we) begin
        vld_q[desc_waddr] <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    func_q     <= func_d;
    svc_q      <= svc_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    pend_q     <= pend_d;
    drop_q     <= drop_d;
    busy_q     <= busy_d;
    deps_q     <= deps_d;
    if (load_out) begin
      out_chosen_q <= (func_q == FUNC_TICK) ? '0 : CHOSE_W'(best_idx_q);
      out_drop_q   <= drop_q;
      out_busy_q   <= busy_q;
      out_deps_q   <= deps_q;
      out_wait_q   <= wait_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign chosen_queue_o = out_chosen_q;
  assign dropped_o      = out_drop_q;
  assign any_busy_o     = out_busy_q;
  assign departures_o   = out_deps_q;
  assign wait_total_o   = out_wait_q;

endmodule
`default_nettype wire
